[sv/mvc_pkg.sv]
package mvc_pkg;

    // default sizes
    localparam int DELAY_DEPTH_DEF  = 4096;
    localparam int VOICES_DEF       = 5;
    localparam int SINE_ENTRIES_DEF = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_STEP   = 3'd0,
        REG_SWEEP_MAX   = 3'd1,
        REG_WET_LEVEL   = 3'd2,
        REG_VOICE_COUNT = 3'd3,
        REG_EFFECT_EN   = 3'd4
    } cfg_reg_t;

    // register reset values and usable ranges
    localparam logic [19:0] BASE_STEP_RST = 20'd97352;
    localparam logic [19:0] BASE_STEP_LO  = 20'd2921;
    localparam logic [19:0] BASE_STEP_HI  = 20'd778870;
    localparam logic [13:0] SWEEP_RST     = 14'd5120;
    localparam logic [13:0] SWEEP_LO      = 14'd1280;
    localparam logic [13:0] SWEEP_HI      = 14'd12800;
    localparam logic [15:0] WET_RST       = 16'd16384;
    localparam logic [15:0] WET_MAX       = 16'd32768;
    localparam int          COUNT_RST     = 3;

    // 5 ms in q8 samples and samples per ms in q16
    localparam logic [20:0] MIN_DELAY_Q8 = 21'd56471;
    localparam logic [21:0] SPMS_Q16     = 22'd2891294;

    typedef struct packed {
        logic [19:0] base_phase_step;
        logic [13:0] sweep_max_delay;
        logic [15:0] wet_level;
        logic [2:0]  voice_count;
        logic        effect_enable;
    } cfg_t;

    typedef struct packed {
        logic       go;
        logic [2:0] count;
    } spread_t;

    typedef struct packed {
        logic        bypass;
        logic [15:0] sample;
    } item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RANGE,
        ST_LFO,
        ST_DEPTH,
        ST_SCALE,
        ST_TAP,
        ST_READ,
        ST_ACCUM,
        ST_DIV,
        ST_FIX,
        ST_MIX,
        ST_ROUND,
        ST_DONE
    } seq_state_t;

    // per-voice lfo rate multiplier, q16
    function automatic logic [16:0] voice_rate(input logic [2:0] v);
        logic [16:0] r;
        case (v)
            3'd0:    r = 17'd65536;
            3'd1:    r = 17'd67830;
            3'd2:    r = 17'd63242;
            3'd3:    r = 17'd68944;
            3'd4:    r = 17'd61735;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    // per-voice depth multiplier, q16
    function automatic logic [16:0] depth_mult(input logic [2:0] v);
        logic [16:0] r;
        case (v)
            3'd0:    r = 17'd65536;
            3'd1:    r = 17'd59638;
            3'd2:    r = 17'd71434;
            3'd3:    r = 17'd61604;
            3'd4:    r = 17'd70124;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    // per-voice static tap offset, q8 samples
    function automatic logic signed [11:0] offset_q8(input logic [2:0] v);
        logic signed [11:0] r;
        case (v)
            3'd0:    r = 12'sd0;
            3'd1:    r = 12'sd1088;
            3'd2:    r = -12'sd704;
            3'd3:    r = 12'sd1408;
            3'd4:    r = -12'sd1050;
            default: r = 12'sd0;
        endcase
        return r;
    endfunction

    // start phase of voice v among n evenly spread voices: floor(v * 2^32 / n)
    function automatic logic [31:0] spread_phase(input logic [2:0] n, input logic [2:0] v);
        logic [31:0] r;
        r = 32'd0;
        case (n)
            3'd2: if (v == 3'd1) r = 32'd2147483648;
            3'd3: begin
                if (v == 3'd1) r = 32'd1431655765;
                if (v == 3'd2) r = 32'd2863311530;
            end
            3'd4: begin
                if (v == 3'd1) r = 32'd1073741824;
                if (v == 3'd2) r = 32'd2147483648;
                if (v == 3'd3) r = 32'd3221225472;
            end
            3'd5: begin
                if (v == 3'd1) r = 32'd858993459;
                if (v == 3'd2) r = 32'd1717986918;
                if (v == 3'd3) r = 32'd2576980377;
                if (v == 3'd4) r = 32'd3435973836;
            end
            default: r = 32'd0;
        endcase
        if (v >= n) r = 32'd0;
        return r;
    endfunction

    // floor(2^30 / n) for the voice average
    function automatic logic [30:0] recip(input logic [2:0] n);
        logic [30:0] r;
        case (n)
            3'd1:    r = 31'd1073741824;
            3'd2:    r = 31'd536870912;
            3'd3:    r = 31'd357913941;
            3'd4:    r = 31'd268435456;
            3'd5:    r = 31'd214748364;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

[sv/mvc_front.sv]
module mvc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [15:0]   s_sample_in,
    input  logic          effect_enable,
    input  logic          hold,
    output logic          q_valid,
    output mvc_pkg::item_t q_item,
    input  logic          q_pop
);
    import mvc_pkg::*;

    item_t      ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    // accept while there is room and the delay line is not being cleared
    assign s_ready = (cnt_reg != 2'd2) && !hold;
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // classify each transaction: pass-through or chorus
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg].bypass <= !effect_enable;
            ent_reg[wr_ptr_reg].sample <= s_sample_in;
        end
    end

endmodule

[sv/mvc_back.sv]
module mvc_back #(
    parameter int DELAY_DEPTH  = mvc_pkg::DELAY_DEPTH_DEF,
    parameter int VOICES       = mvc_pkg::VOICES_DEF,
    parameter int SINE_ENTRIES = mvc_pkg::SINE_ENTRIES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mvc_pkg::cfg_t    cfg,
    input  mvc_pkg::spread_t spread,
    input  logic             q_valid,
    input  mvc_pkg::item_t   q_item,
    output logic             q_pop,
    output logic             clearing,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_sample_out
);
    import mvc_pkg::*;

    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LW      = $clog2(SINE_ENTRIES);
    localparam int QUARTER = SINE_ENTRIES / 4;
    localparam int KW      = LW - 1;
    localparam int TS      = AW + 11;
    localparam int TAP_MAX = (DELAY_DEPTH - 2) * 256;
    localparam int RST_CNT = (VOICES < COUNT_RST) ? VOICES : COUNT_RST;

    // quarter-wave sine magnitude, q16, built at elaboration
    typedef logic [16:0] mag_tab_t [QUARTER+1];

    function automatic mag_tab_t build_mag_tab();
        mag_tab_t        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = longint'(k) << (18 - LW);
            x2 = (x * x) >> 16;
            t  = (64'd307 * x2) >> 16;
            t  = 64'd5223 - t;
            t  = (t * x2) >> 16;
            t  = 64'd42334 - t;
            t  = (t * x2) >> 16;
            t  = 64'd102944 - t;
            t  = (t * x) >> 16;
            if (t > 64'd65536) t = 64'd65536;
            tab[k] = 17'(t);
        end
        return tab;
    endfunction

    localparam mag_tab_t MAG_TAB = build_mag_tab();

    seq_state_t state_reg, state_next;

    logic [15:0]        mem [DELAY_DEPTH];
    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      wp_reg;
    logic [31:0]        phase_reg [VOICES];
    logic [VW-1:0]      v_reg;
    logic signed [15:0] dry_reg;
    logic               byp_reg;
    logic [20:0]        maxd_reg;
    logic [19:0]        range_reg;
    logic [16:0]        mod_reg;
    logic [20:0]        vstep_reg;
    logic [36:0]        prod1_reg;
    logic [20:0]        prod2_reg;
    logic [AW+7:0]      tap_reg;
    logic signed [15:0] rd0_reg;
    logic signed [15:0] rd1_reg;
    logic [7:0]         frac_reg;
    logic signed [27:0] sum_reg;
    logic [25:0]        sabs_reg;
    logic               sneg_reg;
    logic [25:0]        qest_reg;
    logic signed [24:0] avg_reg;
    logic [38:0]        accmag_reg;
    logic               accneg_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    // control decode
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          load_out;
    logic          last_voice;

    // datapath
    logic [19:0]        step_c;
    logic [13:0]        sweep_c;
    logic [15:0]        wl_c;
    logic [20:0]        maxd_c;
    logic [2:0]         v3;
    logic [LW-1:0]      lfo_idx;
    logic [1:0]         quad;
    logic [KW-1:0]      fold_k;
    logic [16:0]        mag;
    logic [17:0]        mod_sum;
    logic [17:0]        mod_dif;
    logic [16:0]        mod_c;
    logic [20:0]        vstep_c;
    logic signed [TS-1:0] traw;
    logic [AW+7:0]      tap_c;
    logic [AW-1:0]      tap_id;
    logic [AW-1:0]      rd_addr0;
    logic [AW-1:0]      rd_addr1;
    logic [8:0]         wf;
    logic signed [27:0] sum_c;
    logic [25:0]        sabs_c;
    logic [25:0]        qest_c;
    logic [28:0]        rem_c;
    logic [25:0]        q_c;
    logic signed [26:0] qs_c;
    logic signed [41:0] acc_c;
    logic [41:0]        accabs_c;
    logic [15:0]        r_c;
    logic [15:0]        res_c;

    assign clearing     = (state_reg == ST_CLEAR);
    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_data_reg;
    assign last_voice   = (3'(v_reg) == cfg.voice_count - 3'd1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(DELAY_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (q_valid) state_next = q_item.bypass ? ST_DONE : ST_SETUP;
            end
            ST_SETUP: state_next = ST_RANGE;
            ST_RANGE: state_next = ST_LFO;
            ST_LFO:   state_next = ST_DEPTH;
            ST_DEPTH: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_TAP;
            ST_TAP:   state_next = ST_READ;
            ST_READ:  state_next = ST_ACCUM;
            ST_ACCUM: state_next = last_voice ? ST_DIV : ST_LFO;
            ST_DIV:   state_next = ST_FIX;
            ST_FIX:   state_next = ST_MIX;
            ST_MIX:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop     = (state_reg == ST_IDLE) && q_valid;
        mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_SETUP);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wp_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? 16'd0 : dry_reg;
        load_out  = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
    end

    // clamped register values, max sweep delay in q8 samples
    always_comb begin
        step_c  = (cfg.base_phase_step < BASE_STEP_LO) ? BASE_STEP_LO :
                  (cfg.base_phase_step > BASE_STEP_HI) ? BASE_STEP_HI : cfg.base_phase_step;
        sweep_c = (cfg.sweep_max_delay < SWEEP_LO) ? SWEEP_LO :
                  (cfg.sweep_max_delay > SWEEP_HI) ? SWEEP_HI : cfg.sweep_max_delay;
        wl_c    = (cfg.wet_level > WET_MAX) ? WET_MAX : cfg.wet_level;
        maxd_c  = 21'((36'(sweep_c) * 36'(SPMS_Q16) + 36'd32768) >> 16);
    end

    // lfo: quantized phase folded onto the quarter wave
    always_comb begin
        v3      = 3'(v_reg);
        lfo_idx = phase_reg[v_reg][31 -: LW];
        quad    = lfo_idx[LW-1 -: 2];
        fold_k  = quad[0] ? (KW'(QUARTER) - {1'b0, lfo_idx[LW-3:0]}) : {1'b0, lfo_idx[LW-3:0]};
        mag     = MAG_TAB[fold_k];
        mod_sum = 18'd65536 + 18'(mag);
        mod_dif = 18'd65536 - 18'(mag);
        mod_c   = quad[1] ? mod_dif[17:1] : mod_sum[17:1];
        vstep_c = 21'((37'(step_c) * 37'(voice_rate(v3)) + 37'd32768) >> 16);
    end

    // tap position and read addresses
    always_comb begin
        traw  = TS'($signed({1'b0, MIN_DELAY_Q8})) + TS'($signed({1'b0, prod2_reg}))
              + TS'(offset_q8(v3));
        if (traw < TS'(256))
            tap_c = (AW+8)'(256);
        else if (traw > TS'(TAP_MAX))
            tap_c = (AW+8)'(TAP_MAX);
        else
            tap_c = traw[AW+7:0];
        tap_id   = tap_reg[AW+7:8];
        rd_addr0 = wp_reg - tap_id;
        rd_addr1 = wp_reg - tap_id - AW'(1);
    end

    // interpolation, average, mix and output scaling
    always_comb begin
        wf       = 9'd256 - {1'b0, frac_reg};
        sum_c    = sum_reg + 28'(rd0_reg) * 28'($signed({1'b0, wf}))
                 + 28'(rd1_reg) * 28'($signed({1'b0, frac_reg}));
        sabs_c   = 26'(sum_reg[27] ? -sum_reg : sum_reg);
        qest_c   = 26'((57'(sabs_reg) * 57'(recip(cfg.voice_count))) >> 30);
        rem_c    = 29'(sabs_reg) - 29'(qest_reg) * 29'(cfg.voice_count);
        q_c      = (rem_c >= 29'(cfg.voice_count)) ? qest_reg + 26'd1 : qest_reg;
        qs_c     = $signed({1'b0, q_c});
        acc_c    = (42'(dry_reg) <<< 23) + 42'(avg_reg) * 42'($signed({1'b0, wl_c}));
        accabs_c = acc_c[41] ? 42'(-acc_c) : 42'(acc_c);
        r_c      = 16'((54'(accmag_reg) * 54'd32767) >> 38);
        res_c    = accneg_reg ? 16'(-r_c) : r_c;
    end

    // delay line: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd0_reg <= $signed(mem[rd_addr0]);
            rd1_reg <= $signed(mem[rd_addr1]);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wp_reg        <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (state_reg == ST_SETUP) v_reg <= '0;
            if (state_reg == ST_ACCUM && !last_voice) v_reg <= v_reg + VW'(1);
            if (state_reg == ST_ROUND) wp_reg <= wp_reg + AW'(1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // voice phases: spread on reset and on a voice count change, else advance
    always_ff @(posedge aclk) begin
        for (int v = 0; v < VOICES; v++) begin
            if (!aresetn)
                phase_reg[v] <= spread_phase(3'(RST_CNT), 3'(v));
            else if (spread.go)
                phase_reg[v] <= spread_phase(spread.count, 3'(v));
            else if (state_reg == ST_DEPTH && v_reg == VW'(v))
                phase_reg[v] <= phase_reg[v] + 32'(vstep_reg);
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dry_reg <= $signed(q_item.sample);
                byp_reg <= q_item.bypass;
            end
            ST_SETUP: begin
                maxd_reg <= maxd_c;
                sum_reg  <= '0;
            end
            ST_RANGE: range_reg <= (maxd_reg > MIN_DELAY_Q8) ? 20'(maxd_reg - MIN_DELAY_Q8) : '0;
            ST_LFO: begin
                mod_reg   <= mod_c;
                vstep_reg <= vstep_c;
            end
            ST_DEPTH: prod1_reg <= 37'(range_reg) * 37'(depth_mult(v3));
            ST_SCALE: prod2_reg <= 21'((54'(prod1_reg) * 54'(mod_reg)) >> 32);
            ST_TAP:   tap_reg <= tap_c;
            ST_READ:  frac_reg <= tap_reg[7:0];
            ST_ACCUM: sum_reg <= sum_c;
            ST_DIV: begin
                sabs_reg <= sabs_c;
                sneg_reg <= sum_reg[27];
            end
            ST_FIX: begin
                qest_reg <= qest_c;
            end
            ST_MIX: begin
                avg_reg <= 25'(sneg_reg ? -qs_c : qs_c);
            end
            ST_ROUND: begin
                accneg_reg <= acc_c[41];
                accmag_reg <= (accabs_c > 42'(64'd1 << 38)) ? 39'(64'd1 << 38) : 39'(accabs_c);
            end
            default: ;
        endcase
    end

    // output register: dry sample on pass-through, scaled mix otherwise
    always_ff @(posedge aclk) begin
        if (load_out) out_data_reg <= byp_reg ? dry_reg : res_c;
    end

    property p_no_pop_while_clearing;
        @(posedge aclk) disable iff (!aresetn) (state_reg == ST_CLEAR) |-> !q_pop;
    endproperty
    a_no_pop_while_clearing: assert property (p_no_pop_while_clearing)
        else $error("queue popped during delay line clear");

    property p_load_only_when_free;
        @(posedge aclk) disable iff (!aresetn) load_out |-> (!out_valid_reg || m_ready);
    endproperty
    a_load_only_when_free: assert property (p_load_only_when_free)
        else $error("result overwritten before it was taken");

    property p_voice_in_range;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_ACCUM) |-> (3'(v_reg) < cfg.voice_count);
    endproperty
    a_voice_in_range: assert property (p_voice_in_range)
        else $error("voice counter beyond active voice count");

endmodule

[sv/multi_voice_chorus_top.sv]
// channel   | valid / ready        | payload
// ----------+----------------------+----------------------------------
// input     | s_valid / s_ready    | s_sample_in  (signed 16)
// result    | m_valid / m_ready    | m_sample_out (signed 16)
// config    | cfg_valid / cfg_ready| cfg_index (3), cfg_data (20)
//
// a chorus sample passes through the back sequencer one voice at a time (through
// the shared lfo, multiplier and delay line ports); a pass-through sample goes
// straight from idle to done.
// after reset the delay line is cleared one entry per cycle, with s_ready low;
// config writes are taken at any time.
// a two-entry input queue and the output register let either side stall alone.
module multi_voice_chorus_top #(
    parameter int DELAY_DEPTH  = mvc_pkg::DELAY_DEPTH_DEF,
    parameter int VOICES       = mvc_pkg::VOICES_DEF,
    parameter int SINE_ENTRIES = mvc_pkg::SINE_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [15:0]                    s_sample_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_sample_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mvc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mvc_pkg::*;

    localparam int RST_CNT = (VOICES < COUNT_RST) ? VOICES : COUNT_RST;

    cfg_t    cfg_reg;
    spread_t spread;
    logic    cfg_wr;
    logic [2:0] count_c;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    logic    clearing;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // clamp the voice count write and request a phase respread on change
    always_comb begin
        count_c = (cfg_data[2:0] < 3'd1) ? 3'd1 :
                  (cfg_data[2:0] > 3'(VOICES)) ? 3'(VOICES) : cfg_data[2:0];
        spread.count = count_c;
        spread.go    = cfg_wr && (cfg_index == REG_VOICE_COUNT)
                     && (count_c != cfg_reg.voice_count);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_phase_step <= BASE_STEP_RST;
            cfg_reg.sweep_max_delay <= SWEEP_RST;
            cfg_reg.wet_level       <= WET_RST;
            cfg_reg.voice_count     <= 3'(RST_CNT);
            cfg_reg.effect_enable   <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_BASE_STEP:   cfg_reg.base_phase_step <= cfg_data[19:0];
                REG_SWEEP_MAX:   cfg_reg.sweep_max_delay <= cfg_data[13:0];
                REG_WET_LEVEL:   cfg_reg.wet_level       <= cfg_data[15:0];
                REG_VOICE_COUNT: cfg_reg.voice_count     <= count_c;
                REG_EFFECT_EN:   cfg_reg.effect_enable   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mvc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .effect_enable (cfg_reg.effect_enable),
        .hold          (clearing),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    mvc_back #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .VOICES       (VOICES),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .spread       (spread),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

endmodule

[dv/multi_voice_chorus_checker.sv]
`timescale 1ns / 100ps

module multi_voice_chorus_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [15:0]                    s_sample_in,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [15:0]                    m_sample_out,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mvc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import mvc_pkg::*;

    localparam int DEPTH = DELAY_DEPTH_DEF;
    localparam int NV    = VOICES_DEF;

    // voice tables, q16 multipliers and q8 offsets
    localparam longint unsigned VOICE_RATE[NV]  = '{65536, 67830, 63242, 68944, 61735};
    localparam longint unsigned VOICE_DEPTH[NV] = '{65536, 59638, 71434, 61604, 70124};
    localparam longint          VOICE_OFS[NV]   = '{0, 1088, -704, 1408, -1050};

    // model state
    logic signed [15:0] line_mem [DEPTH];
    logic [11:0]        wr_ptr;
    logic [31:0]        lfo_phase [NV];
    logic [19:0]        phase_step_reg;
    logic [13:0]        sweep_reg;
    logic [15:0]        wet_reg;
    logic [2:0]         voices_reg;
    logic               enable_reg;

    logic signed [15:0] expected_samples [$];

    function automatic longint unsigned sine_mod(input logic [31:0] ph);
        logic [31:0]     turn;
        logic [1:0]      quad;
        longint unsigned x, x2, t;
        turn = {ph[31:22], 22'd0};
        quad = turn[31:30];
        x    = turn[29:14];
        if (quad[0])
            x = 65536 - x;
        x2 = (x * x) >> 16;
        t  = (307 * x2) >> 16;
        t  = 5223 - t;
        t  = (t * x2) >> 16;
        t  = 42334 - t;
        t  = (t * x2) >> 16;
        t  = 102944 - t;
        t  = (t * x) >> 16;
        if (t > 65536)
            t = 65536;
        return quad[1] ? (65536 - t) >> 1 : (65536 + t) >> 1;
    endfunction

    task automatic spread_voices();
        for (int v = 0; v < NV; v++)
            lfo_phase[v] = (v < voices_reg) ? 32'((longint'(v) << 32) / voices_reg) : '0;
    endtask

    // one chorus sample through the model
    function automatic logic signed [15:0] chorus_sample(input logic signed [15:0] dry);
        longint unsigned step, maxd, modv, wl, mag;
        longint          range, sum, avg, acc, res, tap;
        int              id, fr, i0, i1;
        logic [11:0]     w;
        if (!enable_reg)
            return dry;
        w = wr_ptr;
        line_mem[w] = dry;
        step = phase_step_reg < BASE_STEP_LO ? BASE_STEP_LO :
               (phase_step_reg > BASE_STEP_HI ? BASE_STEP_HI : phase_step_reg);
        maxd = sweep_reg < SWEEP_LO ? SWEEP_LO : (sweep_reg > SWEEP_HI ? SWEEP_HI : sweep_reg);
        maxd = (maxd * 2891294 + 32768) >> 16;
        range = longint'(maxd) - 56471;
        if (range < 0)
            range = 0;
        sum = 0;
        for (int v = 0; v < voices_reg && v < NV; v++) begin
            modv = sine_mod(lfo_phase[v]);
            lfo_phase[v] = lfo_phase[v] + 32'((step * VOICE_RATE[v] + 32768) >> 16);
            mag = ($unsigned(range) * VOICE_DEPTH[v] * modv) >> 32;
            tap = 56471 + longint'(mag) + VOICE_OFS[v];
            if (tap < 256)
                tap = 256;
            if (tap > (DEPTH - 2) * 256)
                tap = (DEPTH - 2) * 256;
            id = int'(tap >> 8);
            fr = int'(tap & 255);
            i0 = (int'(w) + DEPTH - id) % DEPTH;
            i1 = (int'(w) + DEPTH - id - 1) % DEPTH;
            sum += longint'(line_mem[i0]) * (256 - fr) + longint'(line_mem[i1]) * fr;
        end
        avg = sum / longint'(voices_reg);
        wl  = wet_reg > WET_MAX ? WET_MAX : wet_reg;
        acc = longint'(dry) * (longint'(1) << 23) + avg * longint'(wl);
        if (acc > (longint'(1) << 38))
            acc = longint'(1) << 38;
        if (acc < -(longint'(1) << 38))
            acc = -(longint'(1) << 38);
        if (acc >= 0)
            res = (acc * 32767) >>> 38;
        else
            res = -(((-acc) * 32767) >>> 38);
        wr_ptr = w + 12'd1;
        return 16'(res);
    endfunction

    // watch the three channels
    always @(posedge aclk) begin
        logic [2:0]         n;
        logic signed [15:0] exp_sample;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++)
                line_mem[i] = '0;
            wr_ptr         = '0;
            phase_step_reg = BASE_STEP_RST;
            sweep_reg      = SWEEP_RST;
            wet_reg        = WET_RST;
            voices_reg     = 3'(COUNT_RST);
            enable_reg     = 1'b1;
            spread_voices();
            expected_samples.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            // configuration transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_BASE_STEP:   phase_step_reg = cfg_data[19:0];
                    REG_SWEEP_MAX:   sweep_reg = cfg_data[13:0];
                    REG_WET_LEVEL:   wet_reg = cfg_data[15:0];
                    REG_VOICE_COUNT: begin
                        n = cfg_data[2:0];
                        if (n < 3'd1)
                            n = 3'd1;
                        if (n > 3'(NV))
                            n = 3'(NV);
                        if (n != voices_reg) begin
                            voices_reg = n;
                            spread_voices();
                        end
                    end
                    REG_EFFECT_EN:   enable_reg = cfg_data[0];
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out arrived with none expected, actual %0d",
                           $signed(m_sample_out));
                    fail_count <= fail_count + 1;
                end else begin
                    exp_sample = expected_samples.pop_front();
                    if (exp_sample !== $signed(m_sample_out)) begin
                        $error("sample_out expected %0d actual %0d", exp_sample,
                               $signed(m_sample_out));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // input transaction
            if (s_valid && s_ready)
                expected_samples.push_back(chorus_sample($signed(s_sample_in)));
            outstanding <= expected_samples.size();
        end
    end

endmodule

[dv/multi_voice_chorus_top_test.sv]
`timescale 1ns / 100ps

module multi_voice_chorus_top_test;
    import mvc_pkg::*;

    localparam int STALL_LIMIT = 30000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [15:0]           s_sample_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [15:0]           m_sample_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    idle_cycles;
    int                    samples_sent;
    int                    cfg_writes;
    bit                    gaps_on;

    multi_voice_chorus_top i_dut (.*);

    multi_voice_chorus_checker i_checker (.*);

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int draw_gap();
        return gaps_on ? $urandom_range(0, 9) : 0;
    endfunction

    // result side back-pressure
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("multi_voice_chorus_top verification failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_sample_in <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] value);
        @(negedge aclk);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk) cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // let every expected sample drain before touching registers
    task automatic drain();
        @(negedge aclk) s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_sample(input int shape);
        case (shape)
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 600)) - 300);
            2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    // pick a setting for one register, extremes often
    function automatic logic [19:0] pick_value(input cfg_reg_t r);
        int roll;
        roll = $urandom_range(0, 9);
        case (r)
            REG_BASE_STEP:
                return roll < 2 ? BASE_STEP_LO : roll < 4 ? BASE_STEP_HI :
                       roll < 5 ? 20'($urandom) : 20'($urandom_range(2921, 778870));
            REG_SWEEP_MAX:
                return roll < 2 ? 20'(SWEEP_LO) : roll < 4 ? 20'(SWEEP_HI) :
                       roll < 5 ? 20'($urandom) : 20'($urandom_range(1280, 12800));
            REG_WET_LEVEL:
                return roll < 2 ? 20'd0 : roll < 4 ? 20'(WET_MAX) :
                       roll < 5 ? 20'($urandom) : 20'($urandom_range(0, 32768));
            REG_VOICE_COUNT:
                return roll < 2 ? 20'($urandom) : 20'($urandom_range(1, 5));
            default:
                return roll < 1 ? 20'($urandom) & 20'hffffe : 20'($urandom) | 20'd1;
        endcase
    endfunction

    initial begin
        int shape;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_sample_in  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_cycles  = 0;
        samples_sent = 0;
        cfg_writes   = 0;
        gaps_on      = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: extremes at reset settings, then odd register values
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        drain();
        write_reg(REG_BASE_STEP, 20'd0);
        write_reg(REG_SWEEP_MAX, 20'd0);
        write_reg(REG_WET_LEVEL, 20'hfffff);
        write_reg(REG_VOICE_COUNT, 20'd0);
        write_reg(3'd5, 20'hfffff);
        for (int i = 0; i < 4; i++)
            send_sample(i[0] ? 16'h7fff : 16'h8000);
        drain();
        write_reg(REG_BASE_STEP, 20'hfffff);
        write_reg(REG_SWEEP_MAX, 20'h3fff);
        write_reg(REG_VOICE_COUNT, 20'd7);
        write_reg(3'd7, 20'd0);
        for (int i = 0; i < 4; i++)
            send_sample(16'($urandom));
        drain();
        write_reg(REG_VOICE_COUNT, 20'd6);
        write_reg(REG_EFFECT_EN, 20'd0);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        drain();
        write_reg(REG_EFFECT_EN, 20'd1);
        write_reg(REG_WET_LEVEL, 20'd0);
        write_reg(3'd6, 20'd3);
        send_sample(16'h8000);
        send_sample(16'h4321);
        drain();

        // random phases with fresh settings each time
        for (int ph = 0; ph < 26; ph++) begin
            gaps_on = (ph % 4) != 3;
            for (int r = 0; r < 5; r++)
                if ($urandom_range(0, 2) != 0 || ph == 0)
                    write_reg(cfg_reg_t'(r), pick_value(cfg_reg_t'(r)));
            if ($urandom_range(0, 7) == 0)
                write_reg(3'($urandom_range(5, 7)), 20'($urandom));
            if ($urandom_range(0, 5) != 0)
                write_reg(REG_EFFECT_EN, 20'd1);
            shape = $urandom_range(0, 3);
            for (int i = 0; i < 25; i++)
                send_sample(random_sample($urandom_range(0, 3) == 0 ?
                                          $urandom_range(0, 3) : shape));
            drain();
        end

        $display("ran %0d samples through %0d register writes,", samples_sent, cfg_writes);
        $display("covering bypass, clamped settings and one to five voices");
        if (fail_count == 0)
            $display("multi_voice_chorus_top verification clean");
        else
            $display("multi_voice_chorus_top verification failed");
        $finish;
    end

endmodule
